// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files, clocked on clk_i with active-low reset rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define CMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define CMA_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: hw/rtl/cma_pkg.sv
// constants and types of the centered moving average block
`timescale 1ns / 1ps
`default_nettype none

package cma_pkg;

  localparam int unsigned MAX_HALF_WIDTH = 15;
  localparam int unsigned SAMPLE_BITS    = 24;
  localparam int unsigned CFG_BITS       = 4;

  localparam int unsigned STORE_DEPTH = 2 * MAX_HALF_WIDTH + 2;
  localparam int unsigned SEEN_MAX    = 2 * MAX_HALF_WIDTH + 1;
  localparam int unsigned ADDR_BITS   = $clog2(STORE_DEPTH);
  localparam int unsigned RAM_DEPTH   = 1 << ADDR_BITS;
  localparam int unsigned SUM_BITS    = SAMPLE_BITS + ADDR_BITS;
  localparam int unsigned CNT_BITS    = $clog2(STORE_DEPTH + 1);
  localparam int unsigned SEEN_BITS   = $clog2(SEEN_MAX + 1);
  localparam int unsigned H_BITS      = $clog2(MAX_HALF_WIDTH + 1);
  localparam int unsigned STEP_BITS   = $clog2(SUM_BITS + 1);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/cma_if.sv
// stream and configuration interfaces of the centered moving average block
`timescale 1ns / 1ps
`default_nettype none

interface cma_in_if import cma_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          final_req;

  modport source (output valid, output sample, output final_req, input ready);
  modport sink (input valid, input sample, input final_req, output ready);
endinterface

interface cma_out_if import cma_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic                          last_out;

  modport source (output valid, output mean, output last_out, input ready);
  modport sink (input valid, input mean, input last_out, output ready);
endinterface

interface cma_cfg_if import cma_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] half_width;

  modport source (output valid, output half_width, input ready);
  modport sink (input valid, input half_width, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cma_ram.sv
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module cma_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/cma_div.sv
// bit-serial signed divider of the window sum by the point count
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cma_div import cma_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic signed [SUM_BITS-1:0] dividend_i,
  input  wire logic        [CNT_BITS-1:0] divisor_i,
  output div_stat_t                       stat_o,
  output logic signed [SAMPLE_BITS-1:0]   quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 neg_q, neg_d;
  logic [STEP_BITS-1:0] cnt_q, cnt_d;
  logic [SUM_BITS-1:0]  dq_q, dq_d;
  logic [CNT_BITS-1:0]  rem_q, rem_d;
  logic [CNT_BITS-1:0]  dvs_q, dvs_d;

  logic [CNT_BITS:0]    trial;
  logic [CNT_BITS:0]    diff;
  logic                 ge;
  logic [SUM_BITS-1:0]  q_signed;

  // partial remainder stays below the divisor, so one narrow compare per bit
  assign trial = {rem_q, dq_q[SUM_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      neg_d  = dividend_i[SUM_BITS-1];
      dq_d   = dividend_i[SUM_BITS-1] ? SUM_BITS'(-dividend_i) : SUM_BITS'(dividend_i);
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = STEP_BITS'(SUM_BITS);
    end else if (busy_q) begin
      // dividend bits leave at the top, quotient bits enter at the bottom
      dq_d  = {dq_q[SUM_BITS-2:0], ge};
      rem_d = ge ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
      cnt_d = cnt_q - STEP_BITS'(1);
      if (cnt_q == STEP_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  // truncation toward zero: divide magnitudes, then restore the sign
  assign q_signed    = neg_q ? (~dq_q + SUM_BITS'(1)) : dq_q;
  assign quotient_o  = q_signed[SAMPLE_BITS-1:0];
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  `CMA_NEVER(a_busy_and_done, busy_q && done_q, "divider busy and done at once")
  `CMA_ASSERT(a_start_runs, start_i |=> busy_q, "divider did not start")

endmodule

`default_nettype wire

// File: hw/rtl/centered_moving_average.sv
// top level of the centered moving average with truncated window edges
// Usage:
//   in_i  carries one sample word per handshake, final_req marking the last
//         sample of an array; out_o carries one mean word per handshake,
//         last_out marking the result for the array's last index.
//   cfg_i writes half_width (reset value 1); write it only while idle.
//   The result for index m is given after sample m+half_width is taken; the
//   final sample of an array flushes the remaining results: half_width of them,
//   or every result of an array of at most half_width samples. Each result
//   takes an accept step, a read through the store's registered port and a
//   subtract per dropped sample, then the bit-serial divider, one quotient bit
//   per cycle over the 29-bit window sum. A sample with no result skips the divider.
//   A finished mean waits in the output register; the next sample is taken
//   while it waits, and the block stalls only when a new mean is ready and the
//   register is still full.
//   Reset empties the window and the counts, drops any pending output and sets
//   half_width to 1; the sample store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module centered_moving_average import cma_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cma_in_if.sink     in_i,
  cma_out_if.source  out_o,
  cma_cfg_if.sink    cfg_i
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DROP_RD  = 3'd1;
  localparam logic [2:0] S_DROP_SUB = 3'd2;
  localparam logic [2:0] S_DIV      = 3'd3;
  localparam logic [2:0] S_PUSH     = 3'd4;
  localparam logic [2:0] S_NEXT     = 3'd5;

  logic [2:0]                state_q, state_d;
  logic [CFG_BITS-1:0]       half_width_q;
  logic signed [SUM_BITS-1:0] sum_q, sum_d;
  logic [CNT_BITS-1:0]       p_q, p_d;
  logic [SEEN_BITS-1:0]      seen_q, seen_d;
  logic [SEEN_BITS-1:0]      n_q, n_d;
  logic [ADDR_BITS-1:0]      wp_q, wp_d;
  logic [ADDR_BITS-1:0]      limit_q, limit_d;
  logic [H_BITS-1:0]         h_q, h_d;
  logic [H_BITS-1:0]         d_q, d_d;
  logic                      fin_q, fin_d;
  logic                      emit_q, emit_d;
  logic                      last_q, last_d;
  logic                      flush_q, flush_d;

  logic                      out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] mean_q;
  logic                      last_out_q;
  logic                      out_load;

  logic                      in_accept;
  logic [H_BITS-1:0]         h_cfg;
  logic [H_BITS-1:0]         dstart;

  logic                      ram_we;
  logic [ADDR_BITS-1:0]      ram_waddr;
  logic                      ram_re;
  logic [ADDR_BITS-1:0]      ram_raddr;
  logic [SAMPLE_BITS-1:0]    ram_rdata;

  logic                      div_start;
  div_stat_t                 div_stat;
  logic signed [SAMPLE_BITS-1:0] div_q;

  function automatic logic signed [SUM_BITS-1:0] sext_sum(input logic [SAMPLE_BITS-1:0] x);
    sext_sum = {{(SUM_BITS - SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
  endfunction

  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign h_cfg = (32'(half_width_q) > MAX_HALF_WIDTH) ? H_BITS'(MAX_HALF_WIDTH)
                                                      : H_BITS'(half_width_q);

  // first flush distance: short arrays flush every seen index
  assign dstart = (32'(n_q) < 32'(h_q)) ? H_BITS'(n_q) : (h_q - H_BITS'(1));

  assign ram_waddr = wp_q + ADDR_BITS'(1);
  // oldest window entry: p-1 places behind the newest write
  assign ram_raddr = wp_q - p_q[ADDR_BITS-1:0] + ADDR_BITS'(1);

  assign out_load = (state_q == S_PUSH) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d   = state_q;
    sum_d     = sum_q;
    p_d       = p_q;
    seen_d    = seen_q;
    n_d       = n_q;
    wp_d      = wp_q;
    limit_d   = limit_q;
    h_d       = h_q;
    d_d       = d_q;
    fin_d     = fin_q;
    emit_d    = emit_q;
    last_d    = last_q;
    flush_d   = flush_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    div_start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          ram_we  = 1'b1;
          wp_d    = wp_q + ADDR_BITS'(1);
          sum_d   = sum_q + sext_sum(in_i.sample);
          p_d     = p_q + CNT_BITS'(1);
          h_d     = h_cfg;
          fin_d   = in_i.final_req;
          n_d     = seen_q;
          limit_d = (ADDR_BITS'(h_cfg) << 1) + ADDR_BITS'(1);
          emit_d  = 32'(seen_q) >= 32'(h_cfg);
          last_d  = in_i.final_req && (h_cfg == '0);
          flush_d = 1'b0;
          state_d = S_DROP_RD;
        end
      end
      S_DROP_RD: begin
        if (p_q > CNT_BITS'(limit_q)) begin
          ram_re  = 1'b1;
          state_d = S_DROP_SUB;
        end else if (emit_q) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_DROP_SUB: begin
        sum_d   = sum_q - sext_sum(ram_rdata);
        p_d     = p_q - CNT_BITS'(1);
        state_d = S_DROP_RD;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_load) begin
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (!flush_q) begin
          if (fin_q && (h_q != '0)) begin
            flush_d = 1'b1;
            emit_d  = 1'b1;
            d_d     = dstart;
            limit_d = ADDR_BITS'(dstart) + ADDR_BITS'(h_q) + ADDR_BITS'(1);
            last_d  = (dstart == '0);
            state_d = S_DROP_RD;
          end else if (fin_q) begin
            sum_d   = '0;
            p_d     = '0;
            seen_d  = '0;
            state_d = S_IDLE;
          end else begin
            if (32'(seen_q) < SEEN_MAX) begin
              seen_d = seen_q + SEEN_BITS'(1);
            end
            state_d = S_IDLE;
          end
        end else if (d_q == '0) begin
          sum_d   = '0;
          p_d     = '0;
          seen_d  = '0;
          flush_d = 1'b0;
          state_d = S_IDLE;
        end else begin
          // one step closer to the array end: window shrinks by one
          d_d     = d_q - H_BITS'(1);
          limit_d = ADDR_BITS'(d_q) + ADDR_BITS'(h_q);
          last_d  = (d_q == H_BITS'(1));
          state_d = S_DROP_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      half_width_q <= CFG_BITS'(1);
      sum_q        <= '0;
      p_q          <= '0;
      seen_q       <= '0;
      n_q          <= '0;
      wp_q         <= '0;
      limit_q      <= '0;
      h_q          <= '0;
      d_q          <= '0;
      fin_q        <= 1'b0;
      emit_q       <= 1'b0;
      last_q       <= 1'b0;
      flush_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        half_width_q <= cfg_i.half_width;
      end
      sum_q       <= sum_d;
      p_q         <= p_d;
      seen_q      <= seen_d;
      n_q         <= n_d;
      wp_q        <= wp_d;
      limit_q     <= limit_d;
      h_q         <= h_d;
      d_q         <= d_d;
      fin_q       <= fin_d;
      emit_q      <= emit_d;
      last_q      <= last_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mean_q     <= div_q;
      last_out_q <= last_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.mean     = mean_q;
  assign out_o.last_out = last_out_q;

  cma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.sample),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (p_q),
    .stat_o     (div_stat),
    .quotient_o (div_q)
  );

  `CMA_ASSERT(a_div_count_nonzero, (state_q == S_DIV) |-> (p_q != '0), "zero point count")
  `CMA_ASSERT(a_count_bound, p_q <= CNT_BITS'(STORE_DEPTH), "point count above store depth")
  `CMA_NEVER(a_idle_not_flushing, (state_q == S_IDLE) && flush_q, "flush left open")
  `CMA_ASSERT(a_accept_trims, in_accept |=> (state_q == S_DROP_RD), "accept did not trim")

endmodule

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for the centered moving average: directed table, random arrays
`timescale 1ns / 1ps

module testbench;
  import cma_pkg::*;

  localparam int TOTAL_ITEMS = 450;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 48;
  localparam int LONG_HOLD = 300;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 8388607;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = -8388608;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mean;
    logic                          last;
  } avg_res_t;

  typedef struct packed {
    bit                            set_hw;
    logic [CFG_BITS-1:0]           hw;
    logic signed [SAMPLE_BITS-1:0] sample;
    bit                            fin;
    bit                            typed;
    logic signed [SAMPLE_BITS-1:0] want_mean;
    bit                            want_last;
  } plan_row_t;

  logic clk;
  logic rst_n;

  cma_in_if  in_bus ();
  cma_out_if out_bus ();
  cma_cfg_if cfg_bus ();

  centered_moving_average DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // expected means, oldest first
  avg_res_t avg_q[$];

  // local copy of the averaging state
  logic [CFG_BITS-1:0]           avg_hw;
  logic signed [SAMPLE_BITS-1:0] win_buf [STORE_DEPTH];
  longint                        win_total;
  int                            win_pts;
  int                            seen_cnt;

  int  err_cnt;
  int  cycle_cnt;
  int  samples_sent;
  int  arrays_sent;
  int  means_checked;
  int  cfg_writes;
  int  in_stalls;
  bit  idle_on;
  bit  long_hold_req;
  int  hold_left;
  int  stall_left;
  logic [15:0] hw_used;
  avg_res_t got_want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d means outstanding", cycle_cnt, avg_q.size());
      $display("centered_moving_average test failed");
      $finish;
    end
  end

  function automatic void trim_window(input int limit);
    while (win_pts > limit && win_pts > 0) begin
      win_pts--;
      win_total -= win_buf[win_pts % STORE_DEPTH];
    end
  endfunction

  function automatic void push_mean(input bit last);
    longint q;
    q = win_total / longint'(win_pts == 0 ? 1 : win_pts);
    avg_q.push_back('{mean: q[SAMPLE_BITS-1:0], last: last});
  endfunction

  // one accepted sample: shift in, trim, emit the centered mean(s)
  function automatic void window_step(input logic signed [SAMPLE_BITS-1:0] s, input bit fin);
    int h;
    int n;
    int dstart;
    h = avg_hw;
    n = seen_cnt;
    for (int i = STORE_DEPTH - 1; i > 0; i--) win_buf[i] = win_buf[i-1];
    win_buf[0] = s;
    win_total += s;
    win_pts++;
    trim_window(2 * h + 1);
    if (n >= h) push_mean(fin && h == 0);
    if (fin) begin
      // flush the tail of the array with a shrinking window
      if (h != 0) begin
        dstart = (n < h) ? n : h - 1;
        for (int d = dstart; d >= 0; d--) begin
          trim_window(d + h + 1);
          push_mean(d == 0);
        end
      end
      win_total = 0;
      win_pts = 0;
      seen_cnt = 0;
    end else if (seen_cnt < SEEN_MAX) begin
      seen_cnt++;
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // leaves valid high after the handshake so the next word can follow at once
  task automatic put_sample(input logic signed [SAMPLE_BITS-1:0] s, input bit fin,
                            input bit typed = 1'b0, input avg_res_t typed_res = '0);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.sample    <= s;
    in_bus.final_req <= fin;
    @(posedge clk);
    while (!in_bus.ready) begin
      in_stalls++;
      @(posedge clk);
    end
    window_step(s, fin);
    if (typed) begin
      void'(avg_q.pop_back());
      avg_q.push_back(typed_res);
    end
    samples_sent++;
    if (fin) arrays_sent++;
  endtask

  // wait until every mean is out and the block has gone quiet
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (avg_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_hw(input logic [CFG_BITS-1:0] hw);
    drain();
    cfg_bus.valid      <= 1'b1;
    cfg_bus.half_width <= hw;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    avg_hw = hw;
    hw_used[hw] = 1'b1;
    cfg_writes++;
  endtask

  // output side: check each mean, stall in bursts, long hold on request
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (avg_q.size() == 0) begin
        $error("mean word with nothing expected: mean %0d last_out %0b",
               out_bus.mean, out_bus.last_out);
        err_cnt++;
      end else begin
        got_want = avg_q.pop_front();
        if (out_bus.mean !== got_want.mean) begin
          $error("mean: expected %0d, got %0d", got_want.mean, out_bus.mean);
          err_cnt++;
        end
        if (out_bus.last_out !== got_want.last) begin
          $error("last_out: expected %0b, got %0b", got_want.last, out_bus.last_out);
          err_cnt++;
        end
        means_checked++;
      end
    end
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      out_bus.ready <= 1'b0;
      hold_left--;
    end else if (stall_left != 0) begin
      out_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      out_bus.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 6);
    end
  end

  initial begin
    plan_row_t plan[$];
    plan_row_t row;
    int len;
    int shift_at;
    int pick;
    int n_arrays;

    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.sample = '0;
    in_bus.final_req = 1'b0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.half_width = '0;
    err_cnt = 0;
    cycle_cnt = 0;
    samples_sent = 0;
    arrays_sent = 0;
    means_checked = 0;
    cfg_writes = 0;
    in_stalls = 0;
    idle_on = 1'b0;
    long_hold_req = 1'b0;
    hold_left = 0;
    stall_left = 0;
    hw_used = '0;
    avg_hw = 4'd1;
    win_total = 0;
    win_pts = 0;
    seen_cnt = 0;
    foreach (win_buf[i]) win_buf[i] = '0;

    // reset value of half_width is 1
    plan.push_back('{1'b0, 4'd0, 24'sd100, 1'b1, 1'b1, 24'sd100, 1'b1});
    plan.push_back('{1'b0, 4'd0, S_MAX, 1'b0, 1'b0, 24'sd0, 1'b0});
    plan.push_back('{1'b0, 4'd0, S_MAX, 1'b0, 1'b1, S_MAX, 1'b0});
    plan.push_back('{1'b0, 4'd0, S_MAX, 1'b1, 1'b0, 24'sd0, 1'b0});
    // zero half_width passes samples straight through
    plan.push_back('{1'b1, 4'd0, S_MIN, 1'b0, 1'b1, S_MIN, 1'b0});
    plan.push_back('{1'b0, 4'd0, S_MAX, 1'b1, 1'b1, S_MAX, 1'b1});
    plan.push_back('{1'b0, 4'd0, -24'sd1, 1'b1, 1'b1, -24'sd1, 1'b1});
    // widest window on an array much shorter than it
    plan.push_back('{1'b1, 4'd15, S_MIN, 1'b0, 1'b0, 24'sd0, 1'b0});
    plan.push_back('{1'b0, 4'd0, S_MIN, 1'b0, 1'b0, 24'sd0, 1'b0});
    plan.push_back('{1'b0, 4'd0, 24'sd3, 1'b0, 1'b0, 24'sd0, 1'b0});
    plan.push_back('{1'b0, 4'd0, -24'sd5, 1'b1, 1'b0, 24'sd0, 1'b0});
    // window resized in the middle of an array, grow then shrink
    plan.push_back('{1'b1, 4'd2, 24'sd7, 1'b0, 1'b0, 24'sd0, 1'b0});
    plan.push_back('{1'b0, 4'd0, -24'sd8, 1'b0, 1'b0, 24'sd0, 1'b0});
    plan.push_back('{1'b0, 4'd0, 24'sd1, 1'b0, 1'b0, 24'sd0, 1'b0});
    plan.push_back('{1'b1, 4'd4, 24'sd5, 1'b0, 1'b0, 24'sd0, 1'b0});
    plan.push_back('{1'b0, 4'd0, 24'sd11, 1'b0, 1'b0, 24'sd0, 1'b0});
    plan.push_back('{1'b1, 4'd1, 24'sd9, 1'b0, 1'b0, 24'sd0, 1'b0});
    plan.push_back('{1'b0, 4'd0, -24'sd3, 1'b1, 1'b0, 24'sd0, 1'b0});
    // negative sums truncate toward zero
    plan.push_back('{1'b0, 4'd0, -24'sd1, 1'b0, 1'b0, 24'sd0, 1'b0});
    plan.push_back('{1'b0, 4'd0, -24'sd2, 1'b1, 1'b0, 24'sd0, 1'b0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.set_hw) write_hw(row.hw);
      put_sample(row.sample, row.fin, row.typed, '{mean: row.want_mean, last: row.want_last});
    end

    // receiver holds off while samples keep coming, so the input has to stall
    write_hw(4'd1);
    idle_on = 1'b0;
    long_hold_req = 1'b1;
    for (int k = 0; k < 24; k++) put_sample(rand_sample(), k == 23);

    while (samples_sent < TOTAL_ITEMS) begin
      idle_on = (TOTAL_ITEMS - samples_sent > 80) && ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 5);
      write_hw(pick == 0 ? 4'd0 : pick == 1 ? 4'd15 : CFG_BITS'($urandom_range(0, 15)));
      n_arrays = $urandom_range(1, 3);
      for (int a = 0; a < n_arrays; a++) begin
        // mostly short arrays, some long enough to fill the whole window
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 40)
                                          : $urandom_range(1, 2 * avg_hw + 4);
        shift_at = (len > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, len - 1) : 0;
        for (int k = 0; k < len; k++) begin
          if (shift_at != 0 && k == shift_at) write_hw(CFG_BITS'($urandom_range(0, 15)));
          put_sample(rand_sample(), k == len - 1);
        end
      end
    end

    idle_on = 1'b0;
    drain();

    $display("sent %0d samples in %0d arrays, checked %0d means, %0d input stall cycles",
             samples_sent, arrays_sent, means_checked, in_stalls);
    $display("%0d half_width writes covering %0d of 16 values, zero and fifteen included",
             cfg_writes, $countones(hw_used));
    if (err_cnt == 0 && avg_q.size() == 0) begin
      $display("centered_moving_average test passed");
    end else begin
      $display("centered_moving_average test failed");
    end
    $finish;
  end

endmodule
